>>> rtl/c2l_pkg.sv
// Package for the Cyrillic-to-Latin transliterator.
// Holds word types, lead byte masks and the letter table.
// Depends on nothing.
package c2l_pkg;

	localparam logic [7:0]  LEAD_MARK = 8'hC0;
	localparam logic [11:0] CODE_YO_UC = 12'h401;
	localparam logic [11:0] CODE_YO_LC = 12'h451;
	localparam logic [11:0] CODE_FIRST = 12'h410;
	localparam logic [11:0] CODE_LAST  = 12'h44F;
	localparam logic [7:0]  NUL_CHAR   = 8'h00;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       text_start;
	} text_word_t;

	typedef struct packed {
		logic [7:0] out_char;
		logic       last_of_run;
	} glyph_word_t;

	// up to three letters, emitted c0 first
	typedef struct packed {
		logic [1:0] cnt;
		logic [7:0] c0;
		logic [7:0] c1;
		logic [7:0] c2;
	} run_t;

	function automatic run_t one_char(input logic [7:0] c);
		run_t r;
		r = '{cnt: 2'd1, c0: c, c1: NUL_CHAR, c2: NUL_CHAR};
		return r;
	endfunction

	function automatic run_t two_char(input logic [7:0] a, input logic [7:0] b);
		run_t r;
		r = '{cnt: 2'd2, c0: a, c1: b, c2: NUL_CHAR};
		return r;
	endfunction

	// letter index is the code's offset from the first capital letter
	function automatic run_t letter_run(input logic [4:0] idx);
		run_t r;
		case (idx)
			5'd0:  r = one_char("A");
			5'd1:  r = one_char("B");
			5'd2:  r = one_char("V");
			5'd3:  r = one_char("G");
			5'd4:  r = one_char("D");
			5'd5:  r = one_char("E");
			5'd6:  r = two_char("Z", "H");
			5'd7:  r = one_char("Z");
			5'd8:  r = one_char("I");
			5'd9:  r = one_char("J");
			5'd10: r = one_char("K");
			5'd11: r = one_char("L");
			5'd12: r = one_char("M");
			5'd13: r = one_char("N");
			5'd14: r = one_char("O");
			5'd15: r = one_char("P");
			5'd16: r = one_char("R");
			5'd17: r = one_char("S");
			5'd18: r = one_char("T");
			5'd19: r = one_char("U");
			5'd20: r = one_char("F");
			5'd21: r = one_char("H");
			5'd22: r = two_char("T", "S");
			5'd23: r = two_char("C", "H");
			5'd24: r = two_char("S", "H");
			5'd25: r = '{cnt: 2'd3, c0: "S", c1: "C", c2: "H"};
			5'd27: r = one_char("Y");
			5'd29: r = two_char("J", "E");
			5'd30: r = two_char("J", "U");
			5'd31: r = two_char("J", "A");
			default: r = '{cnt: 2'd0, c0: NUL_CHAR, c1: NUL_CHAR, c2: NUL_CHAR};
		endcase
		return r;
	endfunction

endpackage

>>> rtl/cyrillic_to_latin_transliterator.sv
// An accepted text word goes through word_s1, then run_q, before its first glyph word.
// Throughput: one text word per cycle while glyph_stall is low and each word
// yields at most one glyph; a longer run holds run_q until its last glyph is taken.
// Reset (arst_n low, asynchronous): input and run stages empty, no lead held.
// Top level of the Cyrillic-to-Latin transliterator; uses c2l_pkg.
module cyrillic_to_latin_transliterator (
	input  logic                clk,
	input  logic                arst_n,
	input  c2l_pkg::text_word_t text_word,
	input  logic                text_valid,
	output logic                text_stall,
	output c2l_pkg::glyph_word_t glyph_word,
	output logic                glyph_valid,
	input  logic                glyph_stall
);
	import c2l_pkg::*;

	logic        valid_s1;
	text_word_t  word_s1;
	logic        lead_held_q;
	logic [5:0]  lead_bits_q;
	logic        run_valid_q;
	run_t        run_q;
	logic [1:0]  run_idx_q;

	logic        run_last;
	logic        run_done;
	logic        take_s1;
	logic        held_s1;
	logic        is_lead;
	logic [11:0] code;
	run_t        run_next;
	logic        load_run;

	assign run_last = (run_idx_q == (run_q.cnt - 2'd1));
	assign run_done = run_valid_q && !glyph_stall && run_last;
	assign take_s1  = !run_valid_q || run_done;
	assign text_stall = valid_s1 && !take_s1;

	assign held_s1 = lead_held_q && !word_s1.text_start;
	assign is_lead = ((word_s1.text_byte & LEAD_MARK) == LEAD_MARK);
	assign code    = {lead_bits_q, word_s1.text_byte[5:0]};

	always_comb begin
		run_next = one_char(word_s1.text_byte);
		if (held_s1) begin
			if (code == CODE_YO_UC || code == CODE_YO_LC) begin
				run_next = two_char("Y", "O");
			end else if (code >= CODE_FIRST && code <= CODE_LAST) begin
				run_next = letter_run(5'(code - CODE_FIRST));
			end
		end else if (is_lead) begin
			run_next.cnt = 2'd0;
		end
	end

	assign load_run = valid_s1 && take_s1 && (run_next.cnt != 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!text_stall) begin
			valid_s1 <= text_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!text_stall && text_valid) begin
			word_s1 <= text_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lead_held_q <= 1'b0;
			lead_bits_q <= '0;
		end else if (valid_s1 && take_s1) begin
			if (!held_s1 && is_lead) begin
				lead_held_q <= 1'b1;
				lead_bits_q <= word_s1.text_byte[5:0];
			end else begin
				lead_held_q <= 1'b0;
				lead_bits_q <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_valid_q <= 1'b0;
			run_idx_q   <= '0;
		end else if (load_run) begin
			run_valid_q <= 1'b1;
			run_idx_q   <= '0;
		end else if (run_done) begin
			run_valid_q <= 1'b0;
			run_idx_q   <= '0;
		end else if (run_valid_q && !glyph_stall) begin
			run_idx_q <= run_idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_run) begin
			run_q <= run_next;
		end
	end

	always_comb begin
		glyph_word.last_of_run = run_last;
		case (run_idx_q)
			2'd0:    glyph_word.out_char = run_q.c0;
			2'd1:    glyph_word.out_char = run_q.c1;
			2'd2:    glyph_word.out_char = run_q.c2;
			default: glyph_word.out_char = NUL_CHAR;
		endcase
	end
	assign glyph_valid = run_valid_q;

`ifndef SYNTHESIS
	a_idx_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		run_valid_q |-> (run_q.cnt != 2'd0 && run_idx_q < run_q.cnt))
		else $error("glyph index past end of run");

	a_lead_captured: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && take_s1 && !held_s1 && is_lead) |=> lead_held_q)
		else $error("lead byte not held");

	a_run_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(glyph_valid && !glyph_stall && glyph_word.last_of_run && !valid_s1)
		|=> !glyph_valid)
		else $error("glyph word shown after run ended");

	a_stall_needs_word: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> !text_stall)
		else $error("input stalled with empty input stage");
`endif

endmodule

>>> verif/cyrillic_to_latin_transliterator_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for cyrillic_to_latin_transliterator: directed and random
// UTF-8 text words, with glyph words checked against an in-bench transliterator model.
// Depends on c2l_pkg and the cyrillic_to_latin_transliterator RTL.
module cyrillic_to_latin_transliterator_test;
	import c2l_pkg::*;

	// directed row: typed rows carry their expected letters, others use the model
	typedef struct packed {
		logic [7:0]      b;
		logic            st;
		logic            typed;
		logic [1:0]      n;
		logic [0:2][7:0] ch;
	} text_row_t;

	logic        clk = 1'b0;
	logic        arst_n;
	text_word_t  text_word;
	logic        text_valid;
	logic        text_stall;
	glyph_word_t glyph_word;
	logic        glyph_valid;
	logic        glyph_stall = 1'b0;

	glyph_word_t glyphs_due[$];
	glyph_word_t want;
	int          words_sent = 0;
	int          glyphs_seen = 0;
	int          silent_words = 0;
	int          multi_runs = 0;
	int          mismatches = 0;
	int          send_gap = 30;
	int          rcv_gap = 30;
	logic        hold_arm = 1'b0;
	logic        hold_taken = 1'b0;
	int          hold_left = 0;

	// model state
	logic        held = 1'b0;
	logic [5:0]  held_bits = '0;

	string latin_tab [32] = '{
		"A", "B", "V", "G", "D", "E", "ZH", "Z",
		"I", "J", "K", "L", "M", "N", "O", "P",
		"R", "S", "T", "U", "F", "H", "TS", "CH",
		"SH", "SCH", "", "Y", "", "JE", "JU", "JA"
	};

	text_row_t script [24] = '{
		'{8'h00, 1'b1, 1'b1, 2'd1, {8'h00, 16'h0}},
		'{8'h7F, 1'b0, 1'b1, 2'd1, {8'h7F, 16'h0}},
		'{8'h80, 1'b0, 1'b1, 2'd1, {8'h80, 16'h0}},
		'{8'hD0, 1'b0, 1'b1, 2'd0, 24'h0},
		'{8'h90, 1'b0, 1'b0, 2'd0, 24'h0},
		'{8'hD0, 1'b0, 1'b1, 2'd0, 24'h0},
		'{8'hA9, 1'b0, 1'b1, 2'd3, "SCH"},
		'{8'hD0, 1'b0, 1'b1, 2'd0, 24'h0},
		'{8'h81, 1'b0, 1'b1, 2'd2, {"YO", 8'h00}},
		'{8'hD1, 1'b0, 1'b1, 2'd0, 24'h0},
		'{8'h91, 1'b0, 1'b1, 2'd2, {"YO", 8'h00}},
		'{8'hD1, 1'b0, 1'b1, 2'd0, 24'h0},
		'{8'h8C, 1'b0, 1'b1, 2'd0, 24'h0},
		'{8'hD1, 1'b0, 1'b1, 2'd0, 24'h0},
		'{8'h8F, 1'b0, 1'b0, 2'd0, 24'h0},
		'{8'hC2, 1'b0, 1'b1, 2'd0, 24'h0},
		'{8'hA9, 1'b0, 1'b1, 2'd1, {8'hA9, 16'h0}},
		'{8'hFF, 1'b0, 1'b1, 2'd0, 24'h0},
		'{8'hC0, 1'b0, 1'b1, 2'd1, {8'hC0, 16'h0}},
		'{8'hD0, 1'b0, 1'b1, 2'd0, 24'h0},
		'{8'h41, 1'b1, 1'b1, 2'd1, {"A", 16'h0}},
		'{8'hD0, 1'b0, 1'b1, 2'd0, 24'h0},
		'{8'hD0, 1'b1, 1'b1, 2'd0, 24'h0},
		'{8'h96, 1'b0, 1'b0, 2'd0, 24'h0}
	};

	cyrillic_to_latin_transliterator dut (
		.clk(clk),
		.arst_n(arst_n),
		.text_word(text_word),
		.text_valid(text_valid),
		.text_stall(text_stall),
		.glyph_word(glyph_word),
		.glyph_valid(glyph_valid),
		.glyph_stall(glyph_stall)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int transliterate(input text_word_t w, output logic [0:2][7:0] ch);
		logic [11:0] code;
		string       seq;
		ch = '0;
		if (w.text_start)
			held = 1'b0;
		if (!held) begin
			if ((w.text_byte & LEAD_MARK) == LEAD_MARK) begin
				held = 1'b1;
				held_bits = w.text_byte[5:0];
				return 0;
			end
			ch[0] = w.text_byte;
			return 1;
		end
		held = 1'b0;
		code = {held_bits, w.text_byte[5:0]};
		held_bits = '0;
		if (code == CODE_YO_UC || code == CODE_YO_LC) begin
			seq = "YO";
		end else if (code >= CODE_FIRST && code <= CODE_LAST) begin
			seq = latin_tab[5'(code - CODE_FIRST)];
		end else begin
			ch[0] = w.text_byte;
			return 1;
		end
		for (int i = 0; i < seq.len(); i++)
			ch[i] = seq[i];
		return seq.len();
	endfunction

	task automatic offer(input logic [7:0] b, input logic st, input logic typed,
			input int tn, input logic [0:2][7:0] tch);
		text_word_t      w;
		logic [0:2][7:0] ch;
		int              n;
		glyph_word_t     g;
		w.text_byte = b;
		w.text_start = st;
		@(negedge clk);
		while ($urandom_range(99) < send_gap) begin
			text_valid <= 1'b0;
			@(negedge clk);
		end
		text_word <= w;
		text_valid <= 1'b1;
		@(posedge clk);
		while (text_stall)
			@(posedge clk);
		words_sent++;
		n = transliterate(w, ch);
		if (typed) begin
			n = tn;
			ch = tch;
		end
		if (n == 0)
			silent_words++;
		if (n > 1)
			multi_runs++;
		for (int i = 0; i < n; i++) begin
			g.out_char = ch[i];
			g.last_of_run = (i == n - 1);
			glyphs_due.push_back(g);
		end
	endtask

	// receiver: random stall, plus one long hold-off to back up the input
	always @(negedge clk) begin
		if (hold_arm && !hold_taken) begin
			hold_taken = 1'b1;
			hold_left = 60;
		end
		if (hold_left > 0) begin
			hold_left--;
			glyph_stall <= 1'b1;
		end else begin
			glyph_stall <= ($urandom_range(99) < rcv_gap);
		end
	end

	always @(posedge clk) begin
		if (arst_n && glyph_valid && !glyph_stall) begin
			glyphs_seen++;
			if (glyphs_due.size() == 0) begin
				$error("glyph word with none expected: out_char %h last_of_run %b",
					glyph_word.out_char, glyph_word.last_of_run);
				mismatches++;
			end else begin
				want = glyphs_due.pop_front();
				if (glyph_word.out_char !== want.out_char) begin
					$error("out_char expected %h actual %h", want.out_char,
						glyph_word.out_char);
					mismatches++;
				end
				if (glyph_word.last_of_run !== want.last_of_run) begin
					$error("last_of_run expected %b actual %b", want.last_of_run,
						glyph_word.last_of_run);
					mismatches++;
				end
			end
		end
	end

	initial begin
		#2_000_000;
		$display("FAIL cyrillic_to_latin_transliterator");
		$finish;
	end

	initial begin
		int          kind;
		int          ph_goal;
		logic        st;
		logic [11:0] code;
		arst_n = 1'b0;
		text_valid = 1'b0;
		text_word = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (script[i])
			offer(script[i].b, script[i].st, script[i].typed, int'(script[i].n),
				script[i].ch);

		for (int ph = 0; ph < 3; ph++) begin
			send_gap = (ph == 0) ? 23 : (ph == 1) ? 80 : 0;
			rcv_gap = (ph == 0) ? 80 : (ph == 1) ? 23 : 0;
			if (ph == 2)
				hold_arm = 1'b1;
			ph_goal = words_sent + 95;
			while (words_sent < ph_goal) begin
				kind = $urandom_range(99);
				st = ($urandom_range(7) == 0);
				if (kind < 55) begin
					code = 12'($urandom_range(12'h45F, 12'h400));
					offer({2'b11, code[11:6]}, st, 1'b0, 0, '0);
					offer({2'b10, code[5:0]}, 1'b0, 1'b0, 0, '0);
				end else if (kind < 75) begin
					offer(8'($urandom_range(8'h7F)), st, 1'b0, 0, '0);
				end else if (kind < 85) begin
					// broken pair: lead followed by another lead-type byte
					offer(8'hC0 | 8'($urandom_range(63)), st, 1'b0, 0, '0);
					offer(8'hC0 | 8'($urandom_range(63)), 1'($urandom_range(1)),
						1'b0, 0, '0);
				end else begin
					offer(8'($urandom_range(255)), ($urandom_range(3) == 0), 1'b0, 0, '0);
				end
			end
		end

		@(negedge clk);
		text_valid <= 1'b0;
		while (glyphs_due.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		$display("Sent %0d text words (%0d silent, %0d multi-letter) under three idle mixes",
			words_sent, silent_words, multi_runs);
		$display("Checked %0d glyph words, including a 60-cycle receiver hold-off",
			glyphs_seen);
		if (mismatches == 0 && glyphs_due.size() == 0)
			$display("PASS cyrillic_to_latin_transliterator");
		else
			$display("FAIL cyrillic_to_latin_transliterator");
		$finish;
	end

endmodule

>>> files.f
rtl/c2l_pkg.sv
rtl/cyrillic_to_latin_transliterator.sv
verif/cyrillic_to_latin_transliterator_test.sv
